// File: hw/rtl/ppmd_pkg.sv
`default_nettype none

package ppmd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_AW = 3;
	localparam logic [CFG_AW-1:0] CFG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_SYNC_GAP      = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_MIN_WIDTH     = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_MAX_WIDTH     = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_TOLERANCE     = 3'd4;

	// Register reset values
	localparam logic [4:0]  RST_CHANNEL_COUNT = 5'd8;
	localparam logic [15:0] RST_SYNC_GAP      = 16'd3000;
	localparam logic [15:0] RST_MIN_WIDTH     = 16'd1000;
	localparam logic [15:0] RST_MAX_WIDTH     = 16'd2000;
	localparam logic [15:0] RST_TOLERANCE     = 16'd100;

	// Result event codes
	localparam logic [2:0] EV_SYNC   = 3'd0;
	localparam logic [2:0] EV_STORE  = 3'd1;
	localparam logic [2:0] EV_REJECT = 3'd2;
	localparam logic [2:0] EV_BEYOND = 3'd3;
	localparam logic [2:0] EV_READ   = 3'd4;

	// Request kinds on the input tuser bit
	localparam logic ACT_EDGE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Pulse counter saturates here
	localparam logic [4:0] PULSE_SAT = 5'd31;

	typedef struct packed {
		logic [4:0]  channel_count;
		logic [15:0] sync_gap;
		logic [15:0] min_width;
		logic [15:0] max_width;
		logic [15:0] tolerance;
	} cfg_t;

	// Outcome of one edge request, plus table write control
	typedef struct packed {
		logic [2:0]  event_res;
		logic [4:0]  channel;
		logic [15:0] width;
		logic        store;
	} edge_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ppmd_ram.sv
`default_nettype none

module ppmd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ppmd_edge.sv
`default_nettype none

module ppmd_edge #(
	parameter int unsigned MAX_CHANNELS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [31:0]       stamp,
	input  wire ppmd_pkg::cfg_t    cfg,
	output ppmd_pkg::edge_res_t    res
);

	localparam logic [5:0] MAX_CH6 = 6'(MAX_CHANNELS);

	logic [31:0] last_stamp_q;
	logic [4:0]  pulse_q;

	logic [31:0] interval;
	logic [15:0] intv16;
	logic        is_sync;
	logic [5:0]  cc6;
	logic [5:0]  eff_count;
	logic        beyond;
	logic [15:0] lo_bound;
	logic [16:0] hi_bound;
	logic        in_window;

	// Interval since previous edge, modular
	assign interval = stamp - last_stamp_q;
	assign intv16   = interval[15:0];
	assign is_sync  = interval > {16'd0, cfg.sync_gap};

	// Channel count limited to table depth
	assign cc6       = {1'b0, cfg.channel_count};
	assign eff_count = (cc6 > MAX_CH6) ? MAX_CH6 : cc6;
	assign beyond    = (pulse_q == 5'd0) || ({1'b0, pulse_q} > eff_count);

	// Acceptance window; lower bound clamps at zero, upper keeps the carry
	assign lo_bound  = (cfg.min_width > cfg.tolerance) ? (cfg.min_width - cfg.tolerance)
	                                                   : 16'd0;
	assign hi_bound  = {1'b0, cfg.max_width} + {1'b0, cfg.tolerance};
	assign in_window = (intv16 > lo_bound) && ({1'b0, intv16} < hi_bound);

	// Classify the edge
	always_comb begin
		res.channel = pulse_q;
		res.width   = intv16;
		res.store   = 1'b0;
		if (is_sync) begin
			res.event_res = ppmd_pkg::EV_SYNC;
			res.channel   = 5'd0;
			res.width     = (interval[31:16] != 16'd0) ? 16'hFFFF : intv16;
		end else if (beyond) begin
			res.event_res = ppmd_pkg::EV_BEYOND;
		end else if (in_window) begin
			res.event_res = ppmd_pkg::EV_STORE;
			res.store     = 1'b1;
		end else begin
			res.event_res = ppmd_pkg::EV_REJECT;
		end
	end

	// Timing state: last stamp and pulse counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= 32'd0;
			pulse_q      <= 5'd0;
		end else if (take) begin
			last_stamp_q <= stamp;
			if (is_sync) begin
				pulse_q <= 5'd1;
			end else if (pulse_q < ppmd_pkg::PULSE_SAT) begin
				pulse_q <= pulse_q + 5'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ppm_frame_decoder_core.sv
`default_nettype none

// Channel  Dir  Fields (low bit first)
// s_*      in   tuser: action[0]; tdata: stamp[31:0], read_channel[36:32]
// m_*      out  tuser: event_res[2:0]; tdata: channel[4:0], width[20:5]
// cfg_*    in   cfg_addr selects register, cfg_data[15:0] value, cfg_we strobe
//
// One request per cycle sustained while m_tready is high; each result passes through
// stage 1, which waits for the registered table RAM read, then the output register.
// Edge requests are classified in the accept cycle and in-window widths are written to
// the table then, so a read right behind a write sees the new value.
// Reset clears timing state, pipeline valids and per-entry valid bits; no clearing pass.
// s_tready drops only while stage and output register are full and m_tready is low.
module ppm_frame_decoder_core #(
	parameter int unsigned MAX_CHANNELS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [39:0]                   s_tdata,  // stamp, read_channel
	input  wire logic [0:0]                    s_tuser,  // action
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [23:0]                   m_tdata,  // channel, width
	output logic      [2:0]                    m_tuser,  // event_res
	input  wire logic                          cfg_we,
	input  wire logic [ppmd_pkg::CFG_AW-1:0]   cfg_addr,
	input  wire logic [15:0]                   cfg_data
);

	localparam int unsigned AW = $clog2(MAX_CHANNELS > 1 ? MAX_CHANNELS : 2);
	localparam logic [5:0]  MAX_CH6 = 6'(MAX_CHANNELS);

	ppmd_pkg::cfg_t      cfg_q;
	ppmd_pkg::edge_res_t edge_res;

	logic        take;
	logic        take_edge;
	logic        take_read;
	logic [31:0] in_stamp;
	logic [4:0]  in_rch;
	logic        rd_in_range;

	logic          ram_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [15:0]   ram_rdata;
	logic [MAX_CHANNELS-1:0] tbl_valid_q;

	logic        valid_s1;
	logic [2:0]  event_s1;
	logic [4:0]  channel_s1;
	logic [15:0] width_s1;
	logic        rd_s1;
	logic        rdok_s1;
	logic        adv_s1;

	logic        out_valid_q;
	logic [2:0]  out_event_q;
	logic [4:0]  out_channel_q;
	logic [15:0] out_width_q;

	// Request decode
	assign in_stamp  = s_tdata[31:0];
	assign in_rch    = s_tdata[36:32];
	assign take      = s_tvalid && s_tready;
	assign take_edge = take && (s_tuser[0] == ppmd_pkg::ACT_EDGE);
	assign take_read = take && (s_tuser[0] == ppmd_pkg::ACT_READ);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= ppmd_pkg::RST_CHANNEL_COUNT;
			cfg_q.sync_gap      <= ppmd_pkg::RST_SYNC_GAP;
			cfg_q.min_width     <= ppmd_pkg::RST_MIN_WIDTH;
			cfg_q.max_width     <= ppmd_pkg::RST_MAX_WIDTH;
			cfg_q.tolerance     <= ppmd_pkg::RST_TOLERANCE;
		end else if (cfg_we) begin
			case (cfg_addr)
				ppmd_pkg::CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[4:0];
				ppmd_pkg::CFG_SYNC_GAP:      cfg_q.sync_gap      <= cfg_data;
				ppmd_pkg::CFG_MIN_WIDTH:     cfg_q.min_width     <= cfg_data;
				ppmd_pkg::CFG_MAX_WIDTH:     cfg_q.max_width     <= cfg_data;
				ppmd_pkg::CFG_TOLERANCE:     cfg_q.tolerance     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge timing and classification
	ppmd_edge #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take_edge),
		.stamp  (in_stamp),
		.cfg    (cfg_q),
		.res    (edge_res)
	);

	// Channel table: stored channel k lives at entry k-1
	assign ram_we      = take_edge && edge_res.store;
	assign wr_addr     = AW'(edge_res.channel - 5'd1);
	assign rd_in_range = (in_rch != 5'd0) && ({1'b0, in_rch} <= MAX_CH6);
	assign rd_addr     = AW'(in_rch - 5'd1);

	ppmd_ram #(
		.WIDTH (16),
		.DEPTH (MAX_CHANNELS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (edge_res.width),
		.re    (take_read),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Per-entry written marks; unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_valid_q <= '0;
		end else if (ram_we) begin
			tbl_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Flow control
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || !out_valid_q || m_tready;

	// Stage 1: waits for table read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1 <= take_read;
			if (take_read) begin
				event_s1   <= ppmd_pkg::EV_READ;
				channel_s1 <= in_rch;
				width_s1   <= 16'd0;
				rdok_s1    <= rd_in_range && tbl_valid_q[rd_addr];
			end else begin
				event_s1   <= edge_res.event_res;
				channel_s1 <= edge_res.channel;
				width_s1   <= edge_res.width;
				rdok_s1    <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_event_q   <= event_s1;
			out_channel_q <= channel_s1;
			out_width_q   <= (rd_s1 && rdok_s1) ? ram_rdata : width_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_event_q;
	assign m_tdata  = {3'd0, out_width_q, out_channel_q};

	// A written entry is marked valid on the next cycle
	a_wr_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> tbl_valid_q[$past(wr_addr)])
		else $error("table write did not set its valid mark");

	// A result in stage 1 with an empty output register moves on at once
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("stage 1 result not moved to output");

	// Frame sync results carry channel zero
	a_sync_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_event_q == ppmd_pkg::EV_SYNC)) |-> (out_channel_q == 5'd0))
		else $error("sync result with nonzero channel");

endmodule

`default_nettype wire

// File: test/ppm_frame_decoder_checker.sv
`default_nettype none

// Watches the request, result and register ports of the decoder, keeps its own
// copy of the decode state, and compares every result with the oldest prediction.
module ppm_frame_decoder_checker #(
	parameter int unsigned MAX_CHANNELS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic                        s_tready,
	input  wire logic [39:0]                 s_tdata,  // stamp[31:0], read_channel[36:32]
	input  wire logic [0:0]                  s_tuser,  // action[0]
	input  wire logic                        m_tvalid,
	input  wire logic                        m_tready,
	input  wire logic [23:0]                 m_tdata,  // channel[4:0], width[20:5]
	input  wire logic [2:0]                  m_tuser,  // event_res[2:0]
	input  wire logic                        cfg_we,
	input  wire logic [ppmd_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [15:0]                 cfg_data,
	output int                               fail_count,
	output int                               pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [4:0]  channel;
		logic [15:0] width;
	} pulse_result_t;

	// Shadow of the programmed registers and the decode state
	ppmd_pkg::cfg_t dec_cfg;
	logic [31:0]   prev_stamp;
	logic [4:0]    pulse_no;
	logic [15:0]   width_table [MAX_CHANNELS];
	pulse_result_t result_q [$];
	pulse_result_t got;
	pulse_result_t want;
	int            bad_results = 0;

	assign fail_count = bad_results;

	// Decode one request, updating the shadow state for edges
	function automatic pulse_result_t decode_request(input logic act, input logic [31:0] stamp,
			input logic [4:0] rch);
		pulse_result_t r;
		logic [31:0]   span;
		int unsigned   usable;
		logic [16:0]   lo_bound;
		logic [16:0]   hi_bound;
		r = '0;
		if (act == ppmd_pkg::ACT_READ) begin
			r.event_res = ppmd_pkg::EV_READ;
			r.channel = rch;
			if (rch >= 1 && rch <= MAX_CHANNELS)
				r.width = width_table[rch - 5'd1];
		end else begin
			span = stamp - prev_stamp;
			if (span > {16'd0, dec_cfg.sync_gap}) begin
				// frame sync, width saturates
				pulse_no = '0;
				r.event_res = ppmd_pkg::EV_SYNC;
				r.channel = '0;
				r.width = (span > 32'h0000_FFFF) ? 16'hFFFF : span[15:0];
			end else begin
				usable = 32'(dec_cfg.channel_count);
				if (usable > MAX_CHANNELS)
					usable = MAX_CHANNELS;
				if (usable > 32'(ppmd_pkg::PULSE_SAT))
					usable = 32'(ppmd_pkg::PULSE_SAT);
				r.channel = pulse_no;
				r.width = span[15:0];
				if (pulse_no == 5'd0 || 32'(pulse_no) > usable) begin
					r.event_res = ppmd_pkg::EV_BEYOND;
				end else begin
					// lower bound floors at zero, upper bound has a 17th bit
					lo_bound = (dec_cfg.min_width > dec_cfg.tolerance) ?
						{1'b0, dec_cfg.min_width - dec_cfg.tolerance} : 17'd0;
					hi_bound = {1'b0, dec_cfg.max_width} + {1'b0, dec_cfg.tolerance};
					if (span > {15'd0, lo_bound} && span < {15'd0, hi_bound}) begin
						width_table[pulse_no - 5'd1] = span[15:0];
						r.event_res = ppmd_pkg::EV_STORE;
					end else begin
						r.event_res = ppmd_pkg::EV_REJECT;
					end
				end
			end
			if (pulse_no < ppmd_pkg::PULSE_SAT)
				pulse_no = pulse_no + 5'd1;
			prev_stamp = stamp;
		end
		return r;
	endfunction

	task automatic flag_result(input string what, input pulse_result_t seen,
			input pulse_result_t wanted);
		if (bad_results < 10)
			$display("%0t: %s: got ev %0d ch %0d width %0d, expected ev %0d ch %0d width %0d",
				$time, what, seen.event_res, seen.channel, seen.width,
				wanted.event_res, wanted.channel, wanted.width);
		bad_results++;
	endtask

	// Track register writes, check results, predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_cfg.channel_count = ppmd_pkg::RST_CHANNEL_COUNT;
			dec_cfg.sync_gap = ppmd_pkg::RST_SYNC_GAP;
			dec_cfg.min_width = ppmd_pkg::RST_MIN_WIDTH;
			dec_cfg.max_width = ppmd_pkg::RST_MAX_WIDTH;
			dec_cfg.tolerance = ppmd_pkg::RST_TOLERANCE;
			prev_stamp = '0;
			pulse_no = '0;
			for (int i = 0; i < MAX_CHANNELS; i++)
				width_table[i] = '0;
			result_q.delete();
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					ppmd_pkg::CFG_CHANNEL_COUNT: dec_cfg.channel_count = cfg_data[4:0];
					ppmd_pkg::CFG_SYNC_GAP:      dec_cfg.sync_gap = cfg_data;
					ppmd_pkg::CFG_MIN_WIDTH:     dec_cfg.min_width = cfg_data;
					ppmd_pkg::CFG_MAX_WIDTH:     dec_cfg.max_width = cfg_data;
					ppmd_pkg::CFG_TOLERANCE:     dec_cfg.tolerance = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.event_res = m_tuser;
				got.channel = m_tdata[4:0];
				got.width = m_tdata[20:5];
				if (result_q.size() == 0) begin
					flag_result("result with nothing outstanding", got, '0);
				end else begin
					want = result_q.pop_front();
					if (got.event_res != want.event_res || got.channel != want.channel ||
							got.width != want.width)
						flag_result("result mismatch", got, want);
				end
			end
			if (s_tvalid && s_tready)
				result_q.push_back(decode_request(s_tuser[0], s_tdata[31:0], s_tdata[36:32]));
			pending_count <= result_q.size();
		end
	end

endmodule

`default_nettype wire

// File: test/tb_ppm_frame_decoder_core.sv
`default_nettype none

module tb_ppm_frame_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_CH = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_LONG_HOLD = 300;
	localparam int DRAIN_SETTLE = 4;
	localparam logic [ppmd_pkg::CFG_AW-1:0] CFG_UNUSED = 3'd5;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [39:0]       s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic [2:0]        m_tuser;
	logic              cfg_we = 1'b0;
	logic [ppmd_pkg::CFG_AW-1:0] cfg_addr = '0;
	logic [15:0]       cfg_data = '0;
	int                fail_count;
	int                pending_count;

	bit                idle_on = 1'b1;
	bit                rx_long_hold = 1'b0;
	int                rx_hold_left = 0;
	int                quiet_cycles = 0;

	// Stimulus-side view of the programmed setting and of the pulse train
	int unsigned       cur_count = 32'(ppmd_pkg::RST_CHANNEL_COUNT);
	int unsigned       cur_gap = 32'(ppmd_pkg::RST_SYNC_GAP);
	int unsigned       cur_min = 32'(ppmd_pkg::RST_MIN_WIDTH);
	int unsigned       cur_max = 32'(ppmd_pkg::RST_MAX_WIDTH);
	int unsigned       cur_tol = 32'(ppmd_pkg::RST_TOLERANCE);
	logic [31:0]       now_us = '0;
	int                frame_left = 0;

	ppm_frame_decoder_core #(
		.MAX_CHANNELS(MAX_CH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	ppm_frame_decoder_checker #(
		.MAX_CHANNELS(MAX_CH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: no handshake on either side for too long
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random back-pressure bursts plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_long_hold) begin
			rx_long_hold <= 1'b0;
			rx_hold_left = RX_LONG_HOLD;
			m_tready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_hold_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [ppmd_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] cnt_raw, input logic [15:0] gap,
			input logic [15:0] mn, input logic [15:0] mx, input logic [15:0] tol);
		write_reg(ppmd_pkg::CFG_CHANNEL_COUNT, cnt_raw);
		write_reg(ppmd_pkg::CFG_SYNC_GAP, gap);
		write_reg(ppmd_pkg::CFG_MIN_WIDTH, mn);
		write_reg(ppmd_pkg::CFG_MAX_WIDTH, mx);
		write_reg(ppmd_pkg::CFG_TOLERANCE, tol);
		cfg_we <= 1'b0;
		cur_count = 32'(cnt_raw[4:0]);
		cur_gap = 32'(gap);
		cur_min = 32'(mn);
		cur_max = 32'(mx);
		cur_tol = 32'(tol);
	endtask

	// Offer one request, with an optional idle burst ahead of it
	task automatic offer(input logic act, input logic [31:0] stamp, input logic [4:0] rch);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 6) == 0)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, rch, stamp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_edge(input logic [31:0] step_us);
		logic [4:0] junk;
		junk = 5'($urandom_range(0, 31));
		now_us = now_us + step_us;
		offer(ppmd_pkg::ACT_EDGE, now_us, junk);
	endtask

	task automatic send_read(input logic [4:0] rch);
		offer(ppmd_pkg::ACT_READ, $urandom, rch);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] sync_step();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return cur_gap + 1 + $urandom_range(0, 4000);
	endfunction

	// In-window interval, window edges now and then; random if no window
	function automatic logic [31:0] channel_step();
		int unsigned lo;
		int unsigned hi;
		int unsigned lower;
		int unsigned upper;
		lo = (cur_min > cur_tol) ? cur_min - cur_tol : 0;
		hi = cur_max + cur_tol;
		lower = lo + 1;
		upper = (hi == 0) ? 0 : hi - 1;
		if (upper > cur_gap)
			upper = cur_gap;
		if (hi == 0 || lower > upper)
			return $urandom_range(0, cur_gap);
		case ($urandom_range(0, 5))
			0: return lower;
			1: return upper;
			default: return $urandom_range(lower, upper);
		endcase
	endfunction

	function automatic logic [31:0] noise_step();
		case ($urandom_range(0, 3))
			0: return (cur_min > cur_tol) ? cur_min - cur_tol : 0;
			1: return cur_max + cur_tol;
			2: return $urandom_range(0, cur_gap);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Mostly well-formed frames with random widths, some reads and noise
	task automatic run_frames(input int n_items);
		int unsigned eff;
		logic [4:0]  rch;
		eff = (cur_count > MAX_CH) ? MAX_CH : cur_count;
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 7) == 0)
					rch = 5'($urandom_range(0, 31));
				else
					rch = 5'($urandom_range(1, MAX_CH));
				send_read(rch);
			end else if (frame_left == 0) begin
				send_edge(sync_step());
				case ($urandom_range(0, 7))
					0: frame_left = $urandom_range(0, eff);
					1: frame_left = eff + $urandom_range(1, 3);
					default: frame_left = eff;
				endcase
				if (eff == 0)
					frame_left = $urandom_range(0, 3);
			end else begin
				frame_left--;
				if ($urandom_range(0, 6) == 0)
					send_edge(noise_step());
				else
					send_edge(channel_step());
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no sync yet, window edges, count overrun, reads, saturation, wrap
		send_read(5'd1);
		send_edge(32'd500);
		send_edge(32'd5000);
		send_edge(32'd900);
		send_edge(32'd901);
		send_edge(32'd2099);
		send_edge(32'd2100);
		repeat (4) send_edge(32'd1500);
		send_edge(32'd1500);
		send_edge(32'd3000);
		send_read(5'd2);
		send_read(5'd0);
		send_read(5'd31);
		send_read(5'd16);
		send_read(5'd17);
		send_edge(32'd70000);
		send_edge(32'd3001);
		send_edge(32'hFFFF_FFF0 - now_us);
		send_edge(32'd1500);
		send_read(5'd1);
		drain();

		// Full channel count, upper data bits set; long result-side hold-off
		write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
		program_regs(16'hFFF0, 16'd3000, 16'd1000, 16'd2000, 16'd100);
		rx_long_hold <= 1'b1;
		run_frames(70);
		drain();

		// One channel, widest window, largest sync gap; pause midway
		program_regs(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		run_frames(55);
		drain();
		run_frames(20);
		drain();

		// Zero channels and zero sync gap
		program_regs(16'd0, 16'd0, 16'd1000, 16'd2000, 16'd100);
		run_frames(40);
		drain();

		// Count above the table size, empty window
		program_regs(16'd31, 16'd20000, 16'hFFFF, 16'd0, 16'd0);
		run_frames(50);
		drain();

		// Random setting
		program_regs({11'($urandom), 5'($urandom_range(1, 16))},
			16'($urandom_range(3000, 65535)), 16'($urandom_range(0, 3000)),
			16'($urandom_range(3000, 6000)), 16'($urandom_range(0, 500)));
		run_frames(100);
		drain();

		// Last stretch without idling
		idle_on = 1'b0;
		program_regs({11'($urandom), 5'($urandom_range(1, 16))},
			16'($urandom_range(2500, 8000)), 16'($urandom_range(500, 1500)),
			16'($urandom_range(1500, 2500)), 16'($urandom_range(0, 200)));
		run_frames(100);
		drain();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/ppmd_pkg.sv
hw/rtl/ppmd_ram.sv
hw/rtl/ppmd_edge.sv
hw/rtl/ppm_frame_decoder_core.sv
test/ppm_frame_decoder_checker.sv
test/tb_ppm_frame_decoder_core.sv
